// ===== design/uart_8250_register_model_core_macros.svh =====
// Assertion macros shared by the UART register model RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef UART_8250_REGISTER_MODEL_CORE_MACROS_SVH
`define UART_8250_REGISTER_MODEL_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define U8250_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define U8250_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define U8250_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/u8250_pkg.sv =====
// Types and constants for the 8250 UART register model.
// No dependencies; used by u8250_step and the top level.
package u8250_pkg;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TX_DONE = 2'd2,
    OP_RX_BYTE = 2'd3
  } opcode_t;

  // Register offsets from the port base.
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR     = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCRATCH = 3'd7;

  // Interrupt source bits in the pending, active and enable masks.
  localparam logic [3:0] SRC_RX = 4'b0001;
  localparam logic [3:0] SRC_TX = 4'b0010;
  localparam logic [3:0] SRC_LS = 4'b0100;
  localparam logic [3:0] SRC_MS = 4'b1000;
  localparam logic [3:0] SRC_NONE = 4'b0000;

  // IIR identification codes.
  localparam logic [7:0] IIR_LS   = 8'h06;
  localparam logic [7:0] IIR_RX   = 8'h04;
  localparam logic [7:0] IIR_TX   = 8'h02;
  localparam logic [7:0] IIR_MS   = 8'h00;
  localparam logic [7:0] IIR_NONE = 8'h01;

  // Line status bits.
  localparam int LSR_DR   = 0;
  localparam int LSR_OE   = 1;
  localparam int LSR_THRE = 5;
  localparam int LSR_TEMT = 6;
  localparam logic [7:0] LSR_RESET      = 8'h60;
  localparam logic [7:0] LSR_TX_EMPTY   = 8'h60;
  localparam logic [7:0] LSR_READ_CLEAR = 8'h12;

  // Control bits.
  localparam int LCR_DLAB = 7;
  localparam int MCR_DTR  = 0;
  localparam int MCR_RTS  = 1;
  localparam int MCR_OUT1 = 2;
  localparam int MCR_OUT2 = 3;
  localparam int MCR_LOOP = 4;

  // One input item.
  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  reg_offset;
    logic [7:0]  write_data;
    logic [7:0]  rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_level;
    logic        tx_out_valid;
    logic [7:0]  tx_out_byte;
    logic        write_ignored;
    logic        rx_accepted;
    logic [15:0] divisor_value;
  } result_t;

  // Architectural state of the UART.
  typedef struct packed {
    logic [7:0]  rbr;
    logic [7:0]  thr;
    logic        thr_empty;
    logic [3:0]  ier;
    logic [7:0]  lcr;
    logic [4:0]  mcr;
    logic [7:0]  lsr;
    logic [7:0]  msr;
    logic [15:0] divisor;
    logic [7:0]  scratch;
    logic [3:0]  pending;
    logic [3:0]  active;
    logic        irq;
  } state_t;

  localparam state_t STATE_RESET = '{
    rbr: 8'h00, thr: 8'h00, thr_empty: 1'b1, ier: 4'h0, lcr: 8'h00,
    mcr: 5'h00, lsr: LSR_RESET, msr: 8'h00, divisor: 16'h0000,
    scratch: 8'h00, pending: 4'h0, active: 4'h0, irq: 1'b0
  };

endpackage

// ===== design/u8250_step.sv =====
// Next-state and result logic for one item of the UART register model.
// Purely combinational; depends on u8250_pkg.
module u8250_step
  import u8250_pkg::*;
(
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic       dlab;
  logic       loopback;
  logic       clr_en;
  logic [3:0] clr_mask;
  logic [3:0] sig_mask;
  logic [3:0] sig_en;
  logic [3:0] promote;
  logic [4:0] mcr_new;
  logic [7:0] ms_now;
  logic [3:0] ms_delta;
  logic [7:0] word_mask;

  assign dlab      = cur.lcr[LCR_DLAB];
  assign loopback  = cur.mcr[MCR_LOOP];
  assign word_mask = 8'hFF >> (2'd3 - cur.lcr[1:0]);
  assign mcr_new   = item.write_data[4:0];

  // Loopback modem status: inputs come from the modem control outputs.
  assign ms_now = {mcr_new[MCR_OUT2], mcr_new[MCR_OUT1], mcr_new[MCR_DTR],
                   mcr_new[MCR_RTS], 4'h0};
  assign ms_delta = {ms_now[7] ^ cur.msr[7],
                     cur.msr[6] & ~ms_now[6],
                     ms_now[5] ^ cur.msr[5],
                     ms_now[4] ^ cur.msr[4]};

  always_comb begin
    nxt      = cur;
    res      = '0;
    clr_en   = 1'b0;
    clr_mask = SRC_NONE;
    sig_mask = SRC_NONE;
    sig_en   = SRC_NONE;
    promote  = SRC_NONE;

    case (item.opcode)
      // Bus read, with clear-on-read side effects.
      OP_READ: begin
        case (item.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              res.read_data = cur.divisor[7:0];
            end else begin
              res.read_data = cur.rbr;
              nxt.lsr[LSR_DR] = 1'b0;
              clr_en   = 1'b1;
              clr_mask = SRC_RX;
            end
          end
          REG_IER: begin
            res.read_data = dlab ? cur.divisor[15:8] : {4'h0, cur.ier};
          end
          REG_IIR: begin
            if ((cur.active & SRC_LS) != SRC_NONE) begin
              res.read_data = IIR_LS;
            end else if ((cur.active & SRC_RX) != SRC_NONE) begin
              res.read_data = IIR_RX;
            end else if ((cur.active & SRC_TX) != SRC_NONE) begin
              res.read_data = IIR_TX;
            end else if ((cur.active & SRC_MS) != SRC_NONE) begin
              res.read_data = IIR_MS;
            end else begin
              res.read_data = IIR_NONE;
            end
            clr_en   = 1'b1;
            clr_mask = SRC_TX;
          end
          REG_LCR: res.read_data = cur.lcr;
          REG_MCR: res.read_data = {3'h0, cur.mcr};
          REG_LSR: begin
            res.read_data = cur.lsr;
            nxt.lsr  = cur.lsr & ~LSR_READ_CLEAR;
            clr_en   = 1'b1;
            clr_mask = SRC_LS;
          end
          REG_MSR: begin
            res.read_data = cur.msr;
            nxt.msr  = {cur.msr[7:4], 4'h0};
            clr_en   = 1'b1;
            clr_mask = SRC_MS;
          end
          default: res.read_data = cur.scratch;
        endcase
      end

      // Bus write.
      OP_WRITE: begin
        case (item.reg_offset)
          REG_DATA: begin
            if (dlab) begin
              nxt.divisor[7:0] = item.write_data;
            end else if (cur.thr_empty) begin
              nxt.thr_empty = 1'b0;
              nxt.lsr       = cur.lsr & ~LSR_TX_EMPTY;
              nxt.thr       = item.write_data & word_mask;
              clr_en        = 1'b1;
              clr_mask      = SRC_TX;
            end else begin
              res.write_ignored = 1'b1;
            end
          end
          REG_IER: begin
            if (dlab) begin
              nxt.divisor[15:8] = item.write_data;
            end else begin
              nxt.ier     = item.write_data[3:0];
              promote     = cur.pending & item.write_data[3:0];
              nxt.active  = cur.active | promote;
              nxt.pending = cur.pending & ~promote;
              if (promote != SRC_NONE) begin
                nxt.irq = 1'b1;
              end
            end
          end
          REG_IIR: ;
          REG_LCR: nxt.lcr = item.write_data;
          REG_MCR: begin
            nxt.mcr = mcr_new;
            if (mcr_new[MCR_LOOP]) begin
              nxt.msr = {ms_now[7:4], cur.msr[3:0] | ms_delta};
              if ((ms_now[7:4] ^ cur.msr[7:4]) != 4'h0) begin
                nxt.pending = cur.pending | SRC_MS;
              end
              // The modem source goes active without raising the line.
              if (((nxt.pending & cur.ier) & SRC_MS) != SRC_NONE) begin
                nxt.active  = cur.active | SRC_MS;
                nxt.pending = nxt.pending & ~SRC_MS;
              end
            end else begin
              nxt.msr = {4'h0, cur.msr[3:0]};
            end
          end
          REG_LSR, REG_MSR: res.write_ignored = 1'b1;
          default: nxt.scratch = item.write_data;
        endcase
      end

      // Transmit done: the holding register empties.
      OP_TX_DONE: begin
        if (!cur.thr_empty) begin
          nxt.thr_empty = 1'b1;
          nxt.lsr       = cur.lsr | LSR_TX_EMPTY;
          sig_mask      = SRC_TX;
          if (loopback) begin
            if (cur.lsr[LSR_DR]) begin
              nxt.lsr[LSR_OE] = 1'b1;
            end
            nxt.rbr         = cur.thr;
            nxt.lsr[LSR_DR] = 1'b1;
            if (cur.mcr[MCR_OUT2]) begin
              sig_mask = SRC_TX | SRC_RX | SRC_LS;
            end
          end else begin
            res.tx_out_valid = 1'b1;
            res.tx_out_byte  = cur.thr;
          end
        end
      end

      // Byte from the line.
      default: begin
        if (!cur.lsr[LSR_DR] && !loopback) begin
          nxt.rbr         = item.rx_byte;
          nxt.lsr[LSR_DR] = 1'b1;
          sig_mask        = SRC_RX;
          res.rx_accepted = 1'b1;
        end
      end
    endcase

    // Clear one source; the line drops only if nothing else is active.
    if (clr_en) begin
      if ((cur.active & ~clr_mask) == SRC_NONE) begin
        nxt.irq = 1'b0;
      end
      nxt.active  = cur.active & ~clr_mask;
      nxt.pending = cur.pending & ~clr_mask;
    end

    // Signal enabled sources, pend the disabled ones.
    sig_en      = cur.ier & sig_mask;
    nxt.active  = nxt.active | sig_en;
    nxt.pending = nxt.pending | (sig_mask & ~sig_en);
    if (sig_en != SRC_NONE) begin
      nxt.irq = 1'b1;
    end

    res.irq_level     = nxt.irq;
    res.divisor_value = nxt.divisor;
  end

endmodule

// ===== design/uart_8250_register_model_core.sv =====
// Top level of the 8250 UART register model: input register, state, result register.
// Depends on u8250_pkg, u8250_step and uart_8250_register_model_core_macros.svh.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per item: a bus
//   read, a bus write, a transmit-done event or a byte received from the
//   line. The output channel (out_valid/out_ready) returns exactly one
//   result beat per item, in order.
//   A beat is captured in the input register, then the state update and the
//   result are computed in one pass and captured in the result register.
//   Throughput is one item per cycle while the receiver takes every beat; the
//   state feedback loop through u8250_step is the one path that sets that figure.
//   While the receiver stalls, the result register holds its beat and one
//   more item waits in the input register; in_ready then drops.
//   Reset (rst, synchronous) empties both registers and returns the UART
//   to its power-on register values.
`include "uart_8250_register_model_core_macros.svh"

module uart_8250_register_model_core
  import u8250_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  reg_offset,
  input  logic [7:0]  write_data,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        irq_level,
  output logic        tx_out_valid,
  output logic [7:0]  tx_out_byte,
  output logic        write_ignored,
  output logic        rx_accepted,
  output logic [15:0] divisor_value
);

  logic    in_full;
  item_t   in_item;
  logic    advance;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t out_res;

  // An item moves on when the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item <= '{opcode: opcode_t'(opcode), reg_offset: reg_offset,
                   write_data: write_data, rx_byte: rx_byte};
    end
  end

  // One pass of register logic per item.
  u8250_step u_step (
    .cur  (state),
    .item (in_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  // UART register state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign read_data     = out_res.read_data;
  assign irq_level     = out_res.irq_level;
  assign tx_out_valid  = out_res.tx_out_valid;
  assign tx_out_byte   = out_res.tx_out_byte;
  assign write_ignored = out_res.write_ignored;
  assign rx_accepted   = out_res.rx_accepted;
  assign divisor_value = out_res.divisor_value;

  // The interrupt line is only ever high with some source active.
  `U8250_ASSERT_IMPLY(a_irq_has_source, state.irq, state.active != SRC_NONE, "irq without source")
  // An enabled source never stays pending.
  `U8250_ASSERT_ALWAYS(a_no_enabled_pending, (state.pending & state.ier) == SRC_NONE, "enabled pending")
  // Holding-register flag and both LSR empty bits move together.
  `U8250_ASSERT_ALWAYS(a_thre_consistent, (state.lsr[LSR_THRE] == state.thr_empty) && (state.lsr[LSR_TEMT] == state.thr_empty), "LSR empty bits disagree")
  // With the result register empty the block always takes a beat.
  `U8250_ASSERT_IMPLY(a_ready_when_out_free, !out_valid, in_ready, "input stalled with free output")
  // A moved item always shows up as a result beat.
  `U8250_ASSERT_NEXT(a_advance_gives_result, advance, out_valid, "result lost")

endmodule
